### hw/rtl/colt_fusion_predictor_defines.svh
// Assertion macros shared by the verification files of the fusion predictor.
// No dependencies; included by the checker module.
`ifndef COLT_FUSION_PREDICTOR_DEFINES_SVH
`define COLT_FUSION_PREDICTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define CFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cfp_pkg.sv
// Package for the fusion predictor: command and result payload types, operation codes
// and the clearing-pass control struct. No dependencies.
package cfp_pkg;

    // Operation codes of the command field.
    localparam logic [2:0] OP_LOOKUP  = 3'd0;
    localparam logic [2:0] OP_UPDATE  = 3'd1;
    localparam logic [2:0] OP_SPEC    = 3'd2;
    localparam logic [2:0] OP_RECOVER = 3'd3;
    localparam logic [2:0] OP_FLUSH   = 3'd4;

    // Width of the xor shift configuration register.
    localparam int XS_W = 5;

    // Address width of the clearing sweep, enough for the largest table.
    localparam int CLR_ADDR_W = 16;

    // One input command.
    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] pc;
        logic [1:0]  component_predictions;
        logic        outcome;
        logic        own_prediction;
        logic [11:0] entry_index;
        logic [9:0]  history_slot;
        logic [7:0]  saved_history;
    } t_cmd;

    // One result.
    typedef struct packed {
        logic        prediction;
        logic [11:0] entry_index_out;
        logic [9:0]  history_slot_out;
        logic [7:0]  history_seen;
    } t_result;

    // Clearing sweep control sent to both table modules.
    typedef struct packed {
        logic                  active;
        logic [CLR_ADDR_W-1:0] addr;
    } t_clr;

endpackage

### hw/rtl/cfp_hist.sv
// History table of the fusion predictor: one read port with registered data, one
// write port, write-to-read forwarding and the clearing sweep. Depends on cfp_pkg.
module cfp_hist
    import cfp_pkg::*;
#(
    parameter int ENTRIES = 1024,
    parameter int WIDTH   = 8,
    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_clr             i_clr,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam logic [AW-1:0] AMASK = AW'(ENTRIES - 1);

    logic [WIDTH-1:0] r_mem [ENTRIES];
    logic [WIDTH-1:0] r_rd_data;
    logic [AW-1:0]    r_rd_addr;
    logic             r_fwd_vld;
    logic [AW-1:0]    r_fwd_addr;
    logic [WIDTH-1:0] r_fwd_data;

    // Memory write (clearing sweep or functional write) and registered read.
    always_ff @(posedge i_clk) begin
        if (i_clr.active) begin
            r_mem[i_clr.addr[AW-1:0] & AMASK] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr & AMASK] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr & AMASK];
            r_rd_addr <= i_rd_addr & AMASK;
        end
    end

    // Remember the write of the read edge, which the read itself does not see.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else begin
            r_fwd_vld <= i_wr_en;
        end
        r_fwd_addr <= i_wr_addr & AMASK;
        r_fwd_data <= i_wr_data;
    end

    assign o_rd_data = (r_fwd_vld && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_rd_data;

endmodule

### hw/rtl/cfp_ctr.sv
// Counter table of the fusion predictor: registered read, saturating update written
// in the cycle after the read, forwarding and the clearing sweep. Depends on cfp_pkg.
module cfp_ctr
    import cfp_pkg::*;
#(
    parameter int ENTRIES  = 4096,
    parameter int CTR_BITS = 3,
    localparam int AW      = $clog2(ENTRIES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_clr                i_clr,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic                i_upd_en,
    input  logic                i_upd_taken,
    output logic [CTR_BITS-1:0] o_rd_data
);

    localparam logic [CTR_BITS-1:0] CTR_MAX  = '1;
    localparam logic [CTR_BITS-1:0] CTR_HALF = CTR_BITS'(1 << (CTR_BITS - 1));

    logic [CTR_BITS-1:0] r_mem [ENTRIES];
    logic [CTR_BITS-1:0] r_rd_data;
    logic [AW-1:0]       r_rd_addr;
    logic                r_fwd_vld;
    logic [AW-1:0]       r_fwd_addr;
    logic [CTR_BITS-1:0] r_fwd_data;
    logic [CTR_BITS-1:0] cur;
    logic [CTR_BITS-1:0] n_ctr;
    logic [CTR_BITS-1:0] clr_val;

    // Current value of the entry read last edge, with the write of that edge forwarded.
    assign cur       = (r_fwd_vld && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_rd_data;
    assign o_rd_data = cur;

    // Saturating step toward the outcome.
    always_comb begin
        n_ctr = cur;
        if (i_upd_taken) begin
            if (cur != CTR_MAX) begin
                n_ctr = cur + 1'b1;
            end
        end else begin
            if (cur != '0) begin
                n_ctr = cur - 1'b1;
            end
        end
    end

    // Reset value alternates between weakly taken and weakly not taken.
    assign clr_val = i_clr.addr[0] ? (CTR_HALF - 1'b1) : CTR_HALF;

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_clr.active) begin
            r_mem[i_clr.addr[AW-1:0]] <= clr_val;
        end else if (i_upd_en) begin
            r_mem[r_rd_addr] <= n_ctr;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // Capture the update written at the read edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else begin
            r_fwd_vld <= i_upd_en;
        end
        r_fwd_addr <= r_rd_addr;
        r_fwd_data <= n_ctr;
    end

endmodule

### hw/rtl/colt_fusion_predictor.sv
// Top level of the fusion predictor: clearing sequencer, index logic, pipeline and
// result registers. Depends on cfp_pkg, cfp_hist and cfp_ctr.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------
//  command  | in        | start high, busy low     | i_cmd
//  result   | out       | o_done, one cycle        | o_result
//  config   | in        | i_cfg_valid, o_cfg_ready | i_cfg_data
//
// One command is taken every cycle while busy is low; its result passes through the
// registered history read, the registered counter read and the result register.
// After reset a clearing pass writes both tables, one entry of each per cycle, for
// the larger table's addresses (4096 at the defaults); busy stays high meanwhile.
// Results cannot be held off, so there is no back pressure from the result side.
module colt_fusion_predictor
    import cfp_pkg::*;
#(
    parameter int TABLE_ENTRIES   = 4096,
    parameter int HISTORY_ENTRIES = 1024,
    parameter int HISTORY_BITS    = 8,
    parameter int COUNTER_BITS    = 3,
    parameter int N_COMPONENTS    = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  t_cmd            i_cmd,
    output logic            busy,
    output logic            o_done,
    output t_result         o_result,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [XS_W-1:0] i_cfg_data
);

    localparam int CA_W   = $clog2(TABLE_ENTRIES);
    localparam int HA_W   = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
    localparam int PSHIFT = (CA_W > N_COMPONENTS) ? (CA_W - N_COMPONENTS) : 0;
    localparam int CLR_N  = (TABLE_ENTRIES > HISTORY_ENTRIES) ? TABLE_ENTRIES
                                                              : HISTORY_ENTRIES;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam logic [CA_W-1:0] LOW_MASK = CA_W'((TABLE_ENTRIES - 1) >> N_COMPONENTS);
    localparam logic [HA_W-1:0] HMASK    = HA_W'(HISTORY_ENTRIES - 1);
    localparam logic [1:0]      CMASK    = 2'((1 << N_COMPONENTS) - 1);
    localparam logic            HIST_ONE = (HISTORY_ENTRIES == 1);

    logic                    r_clearing;
    logic [CLR_W-1:0]        r_clr_cnt;
    logic [XS_W-1:0]         r_xor_shift;
    logic                    r_s1_vld;
    t_cmd                    r_s1;
    logic                    r_s2_vld;
    logic [2:0]              r_s2_op;
    logic                    r_s2_outcome;
    logic [CA_W-1:0]         r_s2_idx;
    logic [HA_W-1:0]         r_s2_slot;
    logic [HISTORY_BITS-1:0] r_s2_hist;
    logic                    r_done;
    t_result                 r_result;
    t_result                 n_result;

    t_clr                    clr;
    logic                    accept;
    logic [HA_W-1:0]         hist_rd_addr;
    logic [HISTORY_BITS-1:0] hist;
    logic                    hist_wr_en;
    logic [HA_W-1:0]         hist_wr_addr;
    logic [HISTORY_BITS-1:0] hist_wr_data;
    logic [HA_W-1:0]         s1_slot;
    logic [31:0]             hist_shifted;
    logic [CA_W-1:0]         s1_idx;
    logic [CA_W-1:0]         ctr_rd_addr;
    logic [COUNTER_BITS-1:0] ctr;

    assign accept      = start && !busy;
    assign busy        = r_clearing;
    assign o_cfg_ready = 1'b1;
    assign clr.active  = r_clearing;
    assign clr.addr    = CLR_ADDR_W'(r_clr_cnt);

    // Clearing sequencer and the xor shift register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_cnt   <= '0;
            r_xor_shift <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_W'(CLR_N - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_xor_shift <= i_cfg_data;
            end
        end
    end

    // History read address at the command transfer.
    assign hist_rd_addr = ((i_cmd.operation == OP_LOOKUP) ? HA_W'(i_cmd.pc)
                                                          : HA_W'(i_cmd.history_slot)) & HMASK;

    cfp_hist #(
        .ENTRIES (HISTORY_ENTRIES),
        .WIDTH   (HISTORY_BITS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (clr),
        .i_rd_en   (accept),
        .i_rd_addr (hist_rd_addr),
        .i_wr_en   (hist_wr_en),
        .i_wr_addr (hist_wr_addr),
        .i_wr_data (hist_wr_data),
        .o_rd_data (hist)
    );

    // Stage one: counter index from PC, shifted history and component predictions.
    assign s1_slot      = HA_W'(r_s1.pc) & HMASK;
    assign hist_shifted = 32'(hist) << r_xor_shift;
    assign s1_idx       = ((CA_W'(r_s1.pc) ^ CA_W'(hist_shifted)) & LOW_MASK)
                        | CA_W'(32'(r_s1.component_predictions & CMASK) << PSHIFT);
    assign ctr_rd_addr  = (r_s1.operation == OP_LOOKUP) ? s1_idx : CA_W'(r_s1.entry_index);

    // Stage one: history writes for speculative update, recover/flush if HIST_ONE.
    always_comb begin
        hist_wr_en   = 1'b0;
        hist_wr_addr = HA_W'(r_s1.history_slot) & HMASK;
        hist_wr_data = HISTORY_BITS'({hist, r_s1.own_prediction});
        if (r_s1_vld) begin
            case (r_s1.operation)
                OP_SPEC: begin
                    hist_wr_en = 1'b1;
                end
                OP_RECOVER: begin
                    hist_wr_en   = HIST_ONE;
                    hist_wr_addr = '0;
                    hist_wr_data = HISTORY_BITS'({r_s1.saved_history, r_s1.outcome});
                end
                OP_FLUSH: begin
                    hist_wr_en   = HIST_ONE;
                    hist_wr_addr = '0;
                    hist_wr_data = HISTORY_BITS'(r_s1.saved_history);
                end
                default: begin
                    hist_wr_en = 1'b0;
                end
            endcase
        end
    end

    cfp_ctr #(
        .ENTRIES  (TABLE_ENTRIES),
        .CTR_BITS (COUNTER_BITS)
    ) u_ctr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (clr),
        .i_rd_en     (r_s1_vld),
        .i_rd_addr   (ctr_rd_addr),
        .i_upd_en    (r_s2_vld && (r_s2_op == OP_UPDATE)),
        .i_upd_taken (r_s2_outcome),
        .o_rd_data   (ctr)
    );

    // Stage two: result fields, zero for everything but a lookup.
    always_comb begin
        n_result = '0;
        if (r_s2_op == OP_LOOKUP) begin
            n_result.prediction       = ctr[COUNTER_BITS-1];
            n_result.entry_index_out  = 12'(r_s2_idx);
            n_result.history_slot_out = 10'(r_s2_slot);
            n_result.history_seen     = 8'(r_s2_hist);
        end
    end

    // Pipeline valid bits and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
            r_done   <= r_s2_vld;
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_cmd;
        end
        r_s2_op      <= r_s1.operation;
        r_s2_outcome <= r_s1.outcome;
        r_s2_idx     <= s1_idx;
        r_s2_slot    <= s1_slot;
        r_s2_hist    <= hist;
        r_result     <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### hw/rtl/cfp_checker.sv
// Port-level checker for the fusion predictor and its bind to the top level.
// Depends on cfp_pkg and colt_fusion_predictor_defines.svh.
`include "colt_fusion_predictor_defines.svh"

module cfp_checker
    import cfp_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input t_cmd    i_cmd,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    // Every command transfer is followed by a result strobe.
    `CFP_ASSERT_IMP(a_done_follows, i_clk, i_rst_n, start && !busy, ##3 o_done, "missing result")

    // A result strobe always traces back to a command transfer.
    `CFP_ASSERT_IMP(a_done_origin, i_clk, i_rst_n, o_done, $past(start && !busy, 3), "spurious result")

    // Anything but a lookup returns all-zero fields.
    `CFP_ASSERT_IMP(a_zero_result, i_clk, i_rst_n, o_done && ($past(i_cmd.operation, 3) != OP_LOOKUP), o_result == '0, "nonzero result")

    // Leaving reset starts the clearing pass.
    `CFP_ASSERT_NXT(a_clear_start, i_clk, i_rst_n, $past(!i_rst_n), busy, "no clearing pass")

endmodule

bind colt_fusion_predictor cfp_checker u_cfp_checker (.*);

### dv/tb_colt_fusion_predictor.sv
`timescale 1ns / 1ps
// Testbench for colt_fusion_predictor: directed table corners, then branch streams under
// several xor shift settings, checked against an in-bench model of both tables.
// Depends on cfp_pkg and the colt_fusion_predictor RTL.
module tb_colt_fusion_predictor;
    import cfp_pkg::*;

    localparam int          CTR_DEPTH   = 4096;
    localparam int          HIST_DEPTH  = 1024;
    localparam logic [2:0]  CTR_MAX     = 3'd7;
    localparam logic [2:0]  OP_CODE_MAX = 3'd7;
    localparam int unsigned IDLE_LIMIT  = 20000;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            start;
    t_cmd            i_cmd;
    logic            busy;
    logic            o_done;
    t_result         o_result;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [XS_W-1:0] i_cfg_data;

    // Model of the counter and history tables and of the shift register.
    logic [2:0]      ctr_model [CTR_DEPTH];
    logic [7:0]      hist_model [HIST_DEPTH];
    logic [XS_W-1:0] shift_model;
    t_result         last_lookup;
    t_result         pending_results [$];
    logic [9:0]      hot_slots [8];

    int unsigned fail_count = 0;
    int unsigned cmd_count = 0;
    int unsigned result_count = 0;
    int unsigned lookup_count = 0;
    int unsigned update_count = 0;
    int unsigned spec_count = 0;
    int unsigned shift_settings = 0;
    int unsigned idle_cycles = 0;
    bit          steady = 1'b0;

    colt_fusion_predictor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Computes the result of one accepted command and applies it to the model tables.
    function automatic t_result predict_fusion(input t_cmd c);
        t_result     r;
        logic [63:0] mixed;
        logic [11:0] idx;
        logic [9:0]  slot;
        logic [2:0]  ctr;
        r = '0;
        case (c.operation)
            OP_LOOKUP: begin
                // Low index bits mix PC and shifted history; component bits sit on top.
                slot  = c.pc[9:0];
                mixed = {32'd0, c.pc} ^ ({56'd0, hist_model[slot]} << shift_model);
                idx   = {c.component_predictions, mixed[9:0]};
                r.prediction       = ctr_model[idx][2];
                r.entry_index_out  = idx;
                r.history_slot_out = slot;
                r.history_seen     = hist_model[slot];
                last_lookup        = r;
                lookup_count++;
            end
            OP_UPDATE: begin
                ctr = ctr_model[c.entry_index];
                if (c.outcome && ctr != CTR_MAX) begin
                    ctr = ctr + 3'd1;
                end else if (!c.outcome && ctr != 3'd0) begin
                    ctr = ctr - 3'd1;
                end
                ctr_model[c.entry_index] = ctr;
                update_count++;
            end
            OP_SPEC: begin
                hist_model[c.history_slot] = {hist_model[c.history_slot][6:0],
                                              c.own_prediction};
                spec_count++;
            end
            // Recover and flush only act on a single-entry history table, so they leave
            // this configuration alone, as do the unused codes.
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_cmd build_command(input logic [2:0] op, input logic [31:0] pc,
                                           input logic [1:0] comp, input logic outcome,
                                           input logic own, input logic [11:0] eidx,
                                           input logic [9:0] slot, input logic [7:0] saved);
        t_cmd c;
        c.operation             = op;
        c.pc                    = pc;
        c.component_predictions = comp;
        c.outcome               = outcome;
        c.own_prediction        = own;
        c.entry_index           = eidx;
        c.history_slot          = slot;
        c.saved_history         = saved;
        return c;
    endfunction

    function automatic t_cmd random_command();
        return build_command(3'($urandom_range(OP_CODE_MAX)), $urandom, 2'($urandom),
                             1'($urandom), 1'($urandom), 12'($urandom), 10'($urandom),
                             8'($urandom));
    endfunction

    // Drives one command from the falling edge and holds it until the transfer.
    task automatic issue_command(input t_cmd c);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 33) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_cmd = c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_fusion(c));
        cmd_count++;
    endtask

    task automatic stop_commands();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Writes the shift register once every outstanding result has come back.
    task automatic write_xor_shift(input logic [XS_W-1:0] value);
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shift_model = value;
        shift_settings++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly lookup, history shift and counter update chains on a few hot branches,
    // with occasional repairs and fully random commands mixed in.
    task automatic run_branch_stream(input int unsigned n_items);
        t_cmd        c;
        int unsigned sent;
        sent = 0;
        foreach (hot_slots[i]) hot_slots[i] = 10'($urandom);
        hot_slots[0] = '0;
        hot_slots[1] = '1;
        while (sent < n_items) begin
            if ($urandom_range(99) < 75) begin
                c = random_command();
                c.operation = OP_LOOKUP;
                c.pc[9:0]   = hot_slots[$urandom_range(7)];
                issue_command(c);
                c = random_command();
                c.operation      = OP_SPEC;
                c.history_slot   = last_lookup.history_slot_out;
                c.own_prediction = last_lookup.prediction;
                issue_command(c);
                // Odd slots lean taken and even slots lean not taken.
                c = random_command();
                c.operation   = OP_UPDATE;
                c.entry_index = last_lookup.entry_index_out;
                c.outcome     = $urandom_range(99) < (last_lookup.history_slot_out[0] ? 85 : 15);
                issue_command(c);
                sent += 3;
                if ($urandom_range(7) == 0) begin
                    c = random_command();
                    c.operation     = OP_RECOVER;
                    c.saved_history = last_lookup.history_seen;
                    issue_command(c);
                    c.operation = OP_FLUSH;
                    issue_command(c);
                    sent += 2;
                end
            end else begin
                issue_command(random_command());
                sent++;
            end
        end
        stop_commands();
    endtask

    // Field extremes, counter saturation both ways, history shifts and unused codes,
    // all at the reset value of the shift register.
    task automatic test_table_corners();
        issue_command(build_command(OP_LOOKUP, 32'h0, 2'd0, 1'b0, 1'b0, '0, '0, '0));
        issue_command(build_command(OP_LOOKUP, '1, 2'd3, 1'b1, 1'b1, '1, '1, '1));
        issue_command(build_command(OP_LOOKUP, 32'h0000_0001, 2'd1, 1'b0, 1'b1, '0, '0, '0));
        repeat (4) issue_command(build_command(OP_UPDATE, '0, 2'd0, 1'b1, 1'b0, '0, '0, '0));
        repeat (4) issue_command(build_command(OP_UPDATE, '1, 2'd3, 1'b0, 1'b1, '1, '1, '1));
        issue_command(build_command(OP_LOOKUP, 32'h0, 2'd0, 1'b0, 1'b0, '0, '0, '0));
        issue_command(build_command(OP_LOOKUP, '1, 2'd3, 1'b0, 1'b0, '0, '0, '0));
        issue_command(build_command(OP_SPEC, '0, 2'd0, 1'b0, 1'b1, '0, '0, '0));
        issue_command(build_command(OP_SPEC, '0, 2'd0, 1'b0, 1'b1, '0, '1, '0));
        issue_command(build_command(OP_LOOKUP, 32'h0, 2'd2, 1'b0, 1'b0, '0, '0, '0));
        issue_command(build_command(OP_RECOVER, '0, 2'd0, 1'b1, 1'b0, '0, '0, '1));
        issue_command(build_command(OP_FLUSH, '0, 2'd0, 1'b1, 1'b0, '0, '0, '1));
        for (int op = int'(OP_FLUSH) + 1; op <= int'(OP_CODE_MAX); op++) begin
            issue_command(build_command(3'(op), '1, 2'd3, 1'b1, 1'b1, '1, '1, '1));
        end
        issue_command(build_command(OP_LOOKUP, 32'hFFFF_FC00, 2'd2, 1'b0, 1'b0, '0, '0, '0));
        stop_commands();
    endtask

    task automatic test_shift_extremes();
        write_xor_shift('1);
        run_branch_stream(360);
    endtask

    // Zero shift with the sender never pausing.
    task automatic test_back_to_back();
        write_xor_shift('0);
        steady = 1'b1;
        run_branch_stream(360);
        steady = 1'b0;
    endtask

    task automatic test_mid_shifts();
        write_xor_shift(XS_W'(1));
        run_branch_stream(360);
        write_xor_shift(XS_W'($urandom_range(2, 9)));
        run_branch_stream(350);
    endtask

    // Each result is compared with the oldest outstanding prediction.
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_done) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $error("unexpected result with nothing outstanding: %h", o_result);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("prediction", want.prediction, o_result.prediction);
                check_field("entry_index_out", want.entry_index_out,
                            o_result.entry_index_out);
                check_field("history_slot_out", want.history_slot_out,
                            o_result.history_slot_out);
                check_field("history_seen", want.history_seen, o_result.history_seen);
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        // Counters start alternately weakly taken and weakly not taken.
        for (int i = 0; i < CTR_DEPTH; i++) ctr_model[i] = i[0] ? 3'd3 : 3'd4;
        for (int i = 0; i < HIST_DEPTH; i++) hist_model[i] = '0;
        shift_model = '0;
        last_lookup = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_corners();
        test_shift_extremes();
        test_back_to_back();
        test_mid_shifts();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d commands: %0d lookups, %0d counter updates, %0d history shifts,",
                 cmd_count, lookup_count, update_count, spec_count);
        $display("%0d repairs or unused codes; %0d results checked over %0d shift writes.",
                 cmd_count - lookup_count - update_count - spec_count, result_count,
                 shift_settings);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_hist.sv
hw/rtl/cfp_ctr.sv
hw/rtl/colt_fusion_predictor.sv
hw/rtl/cfp_checker.sv
dv/tb_colt_fusion_predictor.sv
